FILE: src/i2cm_pkg.sv
package i2cm_pkg;

  // Register indexes of the configuration port
  typedef enum logic [1:0] {
    CFG_STRETCH_TIMEOUT = 2'd0,
    CFG_RECOVERY_LIMIT  = 2'd1,
    CFG_STOP_HOLD_TICKS = 2'd2
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [7:0] StretchTimeoutRst = 8'd10;
  localparam logic [3:0] RecoveryLimitRst  = 4'd10;
  localparam logic [3:0] StopHoldTicksRst  = 4'd3;

  // Bus command codes
  typedef enum logic [2:0] {
    FN_START = 3'd0,
    FN_STOP  = 3'd1,
    FN_WRITE = 3'd2,
    FN_READ  = 3'd3,
    FN_SACK  = 3'd4,
    FN_RACK  = 3'd5
  } func_e;

  // Sequencer phases
  typedef enum logic [4:0] {
    PH_IDLE   = 5'd0,
    PH_S_SDA  = 5'd1,
    PH_S_SCL  = 5'd2,
    PH_W_DATA = 5'd3,
    PH_W_RISE = 5'd4,
    PH_W_WAIT = 5'd5,
    PH_W_FALL = 5'd6,
    PH_R_DATA = 5'd7,
    PH_R_RISE = 5'd8,
    PH_R_WAIT = 5'd9,
    PH_R_END  = 5'd10,
    PH_K_DATA = 5'd11,
    PH_K_RISE = 5'd12,
    PH_K_WAIT = 5'd13,
    PH_A_DATA = 5'd14,
    PH_A_RISE = 5'd15,
    PH_A_WAIT = 5'd16,
    PH_A_SDA  = 5'd17,
    PH_P_DATA = 5'd18,
    PH_P_RISE = 5'd19,
    PH_P_WAIT = 5'd20,
    PH_P_CHK  = 5'd21,
    PH_P_HIGH = 5'd22,
    PH_P_HOLD = 5'd23
  } phase_e;

  // One tick request as it arrives on the input channel
  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] func;
    logic [7:0] write_data;
    logic       ack_to_send;
    logic       scl_line;
    logic       sda_line;
  } req_t;

  // One tick result
  typedef struct packed {
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_received;
    logic       timed_out;
    logic [3:0] recovery_clocks;
  } res_t;

  // Classified tick held in the queue between front and back
  typedef struct packed {
    logic       cmd_ok;
    func_e      func;
    logic [7:0] write_data;
    logic       ack_to_send;
    logic       scl_line;
    logic       sda_line;
  } tick_t;

  // Configuration values seen by the engine
  typedef struct packed {
    logic [7:0] stretch_timeout;
    logic [3:0] recovery_limit;
    logic [3:0] stop_hold_ticks;
  } cfg_t;

  // Entry phase of each command
  function automatic phase_e first_phase(func_e f);
    phase_e p;
    unique case (f)
      FN_START: p = PH_S_SDA;
      FN_STOP:  p = PH_P_DATA;
      FN_WRITE: p = PH_W_DATA;
      FN_READ:  p = PH_R_DATA;
      FN_SACK:  p = PH_K_DATA;
      FN_RACK:  p = PH_A_DATA;
      default:  p = PH_IDLE;
    endcase
    return p;
  endfunction

endpackage

FILE: src/i2cm_front.sv
module i2cm_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  i2cm_pkg::req_t in_req_i,
  output logic           tick_valid_o,
  input  logic           tick_ready_i,
  output i2cm_pkg::tick_t tick_o
);
  import i2cm_pkg::*;

  tick_t      entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;
  tick_t      cls;

  // Classify: only defined command codes count as a command
  always_comb begin
    cls.cmd_ok      = in_req_i.cmd_valid && (in_req_i.func <= FN_RACK);
    cls.func        = func_e'(in_req_i.func);
    cls.write_data  = in_req_i.write_data;
    cls.ack_to_send = in_req_i.ack_to_send;
    cls.scl_line    = in_req_i.scl_line;
    cls.sda_line    = in_req_i.sda_line;
  end

  assign in_stall_o   = (count_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign tick_valid_o = (count_q != 2'd0);
  assign pop          = tick_valid_o && tick_ready_i;
  assign tick_o       = entry_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold queued ticks
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cls;
    end
  end

endmodule

FILE: src/i2cm_back.sv
module i2cm_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  i2cm_pkg::cfg_t  cfg_i,
  input  logic            tick_valid_i,
  output logic            tick_ready_o,
  input  i2cm_pkg::tick_t tick_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output i2cm_pkg::res_t  out_res_o
);
  import i2cm_pkg::*;

  phase_e     phase_q, phase_d;
  logic [2:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] wait_q, wait_d;
  logic [3:0] rec_q, rec_d;
  logic       tmo_q, tmo_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic [7:0] rd_q, rd_d;
  logic       ack_q, ack_d;
  logic       busy, done;
  logic       step;
  logic       out_valid_q;
  res_t       out_q;
  logic [7:0] lim;
  logic       stretch_hold;
  logic [7:0] hold_cnt;

  assign tick_ready_o = !out_valid_q || !out_stall_i;
  assign step         = tick_valid_i && tick_ready_o;
  assign out_valid_o  = out_valid_q;
  assign out_res_o    = out_q;

  // A zero timeout acts as one tick
  assign lim          = (cfg_i.stretch_timeout == 8'd0) ? 8'd1 : cfg_i.stretch_timeout;
  assign stretch_hold = !tick_i.scl_line && (wait_q < lim);
  assign hold_cnt     = wait_q + 8'd1;

  // Run one tick of the bus sequencer
  always_comb begin
    phase_e cur;
    cur     = phase_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    wait_d  = wait_q;
    rec_d   = rec_q;
    tmo_d   = tmo_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    rd_d    = rd_q;
    ack_d   = ack_q;
    busy    = 1'b0;
    done    = 1'b0;

    // Take a new command only when idle
    if (cur == PH_IDLE && tick_i.cmd_ok) begin
      tmo_d  = 1'b0;
      wait_d = 8'd0;
      bit_d  = 3'd7;
      case (tick_i.func)
        FN_WRITE: shift_d = tick_i.write_data;
        FN_SACK:  shift_d = {7'd0, tick_i.ack_to_send};
        default:  shift_d = 8'd0;
      endcase
      if (tick_i.func == FN_STOP) begin
        rec_d = 4'd0;
      end
      cur = first_phase(tick_i.func);
    end

    phase_d = cur;
    if (cur != PH_IDLE) begin
      busy = 1'b1;
      unique case (cur)
        PH_S_SDA: begin
          sda_d   = 1'b1;
          phase_d = PH_S_SCL;
        end
        PH_S_SCL: begin
          scl_d = 1'b1;
          done  = 1'b1;
        end
        PH_W_DATA: begin
          sda_d   = !shift_d[7];
          phase_d = PH_W_RISE;
        end
        PH_W_RISE, PH_R_RISE, PH_K_RISE, PH_A_RISE, PH_P_RISE: begin
          scl_d   = 1'b0;
          wait_d  = 8'd0;
          phase_d = phase_e'(cur + 5'd1);
        end
        PH_W_WAIT, PH_R_WAIT, PH_K_WAIT, PH_A_WAIT, PH_P_WAIT: begin
          if (stretch_hold) begin
            wait_d = wait_q + 8'd1;
          end else begin
            if (wait_q >= lim) begin
              tmo_d = 1'b1;
            end
            case (cur)
              PH_W_WAIT: phase_d = PH_W_FALL;
              PH_R_WAIT: begin
                shift_d = {shift_q[6:0], tick_i.sda_line};
                if (bit_q == 3'd0) begin
                  phase_d = PH_R_END;
                end else begin
                  bit_d   = bit_q - 3'd1;
                  phase_d = PH_R_DATA;
                end
              end
              PH_K_WAIT: begin
                scl_d = 1'b1;
                done  = 1'b1;
              end
              PH_A_WAIT: begin
                ack_d   = !tick_i.sda_line;
                scl_d   = 1'b1;
                phase_d = PH_A_SDA;
              end
              default: begin
                sda_d   = 1'b0;
                phase_d = PH_P_CHK;
              end
            endcase
          end
        end
        PH_W_FALL: begin
          scl_d   = 1'b1;
          shift_d = {shift_q[6:0], 1'b0};
          if (bit_q == 3'd0) begin
            done = 1'b1;
          end else begin
            bit_d   = bit_q - 3'd1;
            phase_d = PH_W_DATA;
          end
        end
        PH_R_DATA: begin
          sda_d = 1'b0;
          if (bit_d != 3'd7) begin
            scl_d = 1'b1;
          end
          phase_d = PH_R_RISE;
        end
        PH_R_END: begin
          scl_d = 1'b1;
          rd_d  = shift_q;
          done  = 1'b1;
        end
        PH_K_DATA: begin
          sda_d   = shift_d[0];
          phase_d = PH_K_RISE;
        end
        PH_A_DATA: begin
          sda_d   = 1'b0;
          phase_d = PH_A_RISE;
        end
        PH_A_SDA: begin
          sda_d = 1'b1;
          done  = 1'b1;
        end
        PH_P_DATA: begin
          sda_d   = 1'b1;
          phase_d = PH_P_RISE;
        end
        PH_P_CHK: begin
          // Pulse SCL again while a slave still holds SDA, up to the recovery limit
          if (!tick_i.sda_line && (rec_q < cfg_i.recovery_limit)) begin
            rec_d   = rec_q + 4'd1;
            scl_d   = 1'b1;
            phase_d = PH_P_HIGH;
          end else begin
            if (!tick_i.sda_line) begin
              tmo_d = 1'b1;
            end
            if (cfg_i.stop_hold_ticks <= 4'd1) begin
              done = 1'b1;
            end else begin
              wait_d  = 8'd1;
              phase_d = PH_P_HOLD;
            end
          end
        end
        PH_P_HIGH: begin
          scl_d   = 1'b0;
          phase_d = PH_P_CHK;
        end
        PH_P_HOLD: begin
          wait_d = hold_cnt;
          if (hold_cnt >= {4'd0, cfg_i.stop_hold_ticks}) begin
            done = 1'b1;
          end
        end
        default: done = 1'b1;
      endcase
      if (done) begin
        phase_d = PH_IDLE;
      end
    end
  end

  // Update engine state once per consumed tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bit_q       <= 3'd7;
      shift_q     <= 8'd0;
      wait_q      <= 8'd0;
      rec_q       <= 4'd0;
      tmo_q       <= 1'b0;
      scl_q       <= 1'b0;
      sda_q       <= 1'b0;
      rd_q        <= 8'd0;
      ack_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        phase_q <= phase_d;
        bit_q   <= bit_d;
        shift_q <= shift_d;
        wait_q  <= wait_d;
        rec_q   <= rec_d;
        tmo_q   <= tmo_d;
        scl_q   <= scl_d;
        sda_q   <= sda_d;
        rd_q    <= rd_d;
        ack_q   <= ack_d;
      end
      if (tick_ready_o) begin
        out_valid_q <= tick_valid_i;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q.scl_pull_low    <= scl_d;
      out_q.sda_pull_low    <= sda_d;
      out_q.busy_res        <= busy;
      out_q.done_res        <= done;
      out_q.read_data       <= rd_d;
      out_q.ack_received    <= ack_d;
      out_q.timed_out       <= tmo_d;
      out_q.recovery_clocks <= rec_d;
    end
  end

endmodule

FILE: src/i2c_master_bit_engine_core.sv
// A tick request accepted into the queue waits until the sequencer consumes it, and the
// result of that tick is registered. Throughput: one tick request per cycle while no
// result is stalled, set by the single-step sequencer in i2cm_back. A two-entry queue
// separates the classifier from the sequencer. Reset is asynchronous, active low: the
// sequencer goes idle with both lines released and the registers take 10, 10 and 3.
module i2c_master_bit_engine_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [i2cm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [i2cm_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  i2cm_pkg::req_t                 in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output i2cm_pkg::res_t                 out_res_o
);
  import i2cm_pkg::*;

  cfg_t  cfg_q, cfg_d;
  logic  tick_valid, tick_ready;
  tick_t tick;

  // Decode configuration writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_STRETCH_TIMEOUT: cfg_d.stretch_timeout = cfg_wdata_i;
        CFG_RECOVERY_LIMIT:  cfg_d.recovery_limit  = cfg_wdata_i[3:0];
        CFG_STOP_HOLD_TICKS: cfg_d.stop_hold_ticks = cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stretch_timeout <= StretchTimeoutRst;
      cfg_q.recovery_limit  <= RecoveryLimitRst;
      cfg_q.stop_hold_ticks <= StopHoldTicksRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  i2cm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_req_i     (in_req_i),
    .tick_valid_o (tick_valid),
    .tick_ready_i (tick_ready),
    .tick_o       (tick)
  );

  i2cm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .tick_valid_i (tick_valid),
    .tick_ready_o (tick_ready),
    .tick_i       (tick),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_res_o    (out_res_o)
  );

  // A full queue always offers a tick to the sequencer
  a_full_has_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> tick_valid)
    else $error("queue full with no tick offered");

  // A consumed tick shows up as a result on the next cycle
  a_step_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_valid && tick_ready) |=> out_valid_o)
    else $error("consumed tick produced no result");

  // A completing tick is always a busy tick
  a_done_is_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_res_o.done_res) |-> out_res_o.busy_res)
    else $error("done without busy");

  // Nothing is consumed while a result is stalled
  a_stall_blocks_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !tick_ready)
    else $error("sequencer stepped under a stalled result");

endmodule
